### src/lprr_pkg.sv
// ----------------------------------------------------------------------------
// lprr_pkg
// Shared types and constants of the length-prefixed record ring: item
// layouts, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package lprr_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int HDR_BYTES_DEF = 2;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int IDX_W    = 10;
  localparam int USED_W   = 10;

  // Entries of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_PUSH_BEGIN = 2'd0,
    KIND_PUSH_BYTE  = 2'd1,
    KIND_POP        = 2'd2,
    KIND_READ       = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_SEQ_ERR   = 3'd4
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   record_length;
    logic [BYTE_W-1:0]  payload_byte;
    logic [IDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  read_byte;
    logic [LEN_W-1:0]   front_length;
    logic [USED_W-1:0]  used_bytes;
    logic               is_empty;
  } rsp_t;

  // A request after classification by the front.
  typedef struct packed {
    req_t req;
    logic too_long;
  } cmd_t;

endpackage

### src/lprr_ram.sv
// ----------------------------------------------------------------------------
// lprr_ram
// Generic single-write, single-read RAM with a registered read port that
// holds its data while no read is issued.
// ----------------------------------------------------------------------------
module lprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/lprr_front.sv
// ----------------------------------------------------------------------------
// lprr_front
// Accepts request items, classifies push-begin lengths (too long or not,
// and the largest occupancy that still leaves room) and queues them for
// the back.
// ----------------------------------------------------------------------------
module lprr_front import lprr_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int HDR_BYTES = HDR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  req_t                        req,
  output logic                        head_valid,
  output cmd_t                        head,
  output logic [$clog2(CAPACITY)-1:0] head_room,
  input  logic                        head_take
);

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int HDR_W  = 8 * HDR_BYTES;
  localparam int NEED_W = LEN_W + 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LEN_W-1:0] HdrMax =
      (HDR_W >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << HDR_W) - 64'd1);

  logic [NEED_W-1:0] need;
  logic              too_long;
  logic [PTR_W-1:0]  room;
  cmd_t              cmd_in;

  cmd_t              q_cmd  [QUEUE_DEPTH];
  logic [PTR_W-1:0]  q_room [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // Bytes the record takes including its header and the spare byte.
  assign need     = NEED_W'(req.record_length) + NEED_W'(HDR_BYTES + 1);
  assign too_long = (need > NEED_W'(CAPACITY)) || (req.record_length > HdrMax);
  // Eviction continues while the occupancy is above this value.
  assign room     = PTR_W'(NEED_W'(CAPACITY) - need);

  assign cmd_in.req      = req;
  assign cmd_in.too_long = too_long;

  assign req_stall  = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = req_valid && !req_stall;
  assign head_valid = (count != '0);
  assign pop        = head_take && head_valid;
  assign head       = q_cmd[rd_ptr];
  assign head_room  = q_room[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q_cmd[wr_ptr]  <= cmd_in;
        q_room[wr_ptr] <= room;
        wr_ptr         <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/lprr_back.sv
// ----------------------------------------------------------------------------
// lprr_back
// Carries out classified items against the byte ring: header writes,
// eviction of the oldest records, payload bytes, pops and front reads.
// Holds the ring pointers and the cached front header.
// ----------------------------------------------------------------------------
module lprr_back import lprr_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int HDR_BYTES = HDR_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  cmd_t                        head,
  input  logic [$clog2(CAPACITY)-1:0] head_room,
  output logic                        head_take,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output rsp_t                        rsp
);

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int HDR_W  = 8 * HDR_BYTES;
  localparam int CNT_W  = $clog2(HDR_BYTES + 1);
  localparam int MAX_A  = (PTR_W > HDR_W + 1) ? PTR_W : HDR_W + 1;
  localparam int MAX_B  = (MAX_A > IDX_W) ? MAX_A : IDX_W;
  localparam int SUM_W  = MAX_B + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_RD_HDR,
    S_WR_HDR,
    S_RD_BYTE
  } state_t;

  // Reduces a sum of a ring position and an offset below the capacity.
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] cap;
    cap = SUM_W'(CAPACITY);
    if (s >= cap) begin
      wrap = PTR_W'(s - cap);
    end else begin
      wrap = PTR_W'(s);
    end
  endfunction

  state_t            state, state_next;
  logic [PTR_W-1:0]  start_ptr, start_next;
  logic [PTR_W-1:0]  end_ptr, end_next;
  logic [PTR_W-1:0]  used, used_next;
  logic [LEN_W-1:0]  left, left_next;
  logic              push_open, push_open_next;
  logic [HDR_W-1:0]  front_hdr, front_hdr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              evicting, evicting_next;
  logic [LEN_W-1:0]  cur_len, cur_len_next;
  logic [PTR_W-1:0]  cur_room, cur_room_next;
  logic [HDR_W-1:0]  hdr_sh, hdr_sh_next;
  rsp_t              rsp_next;
  logic              rsp_valid_next;

  logic              out_free;
  logic [SUM_W-1:0]  span;
  logic              drop_broken;
  logic [PTR_W-1:0]  drop_start;
  logic [PTR_W-1:0]  drop_used;
  logic [PTR_W-1:0]  end_inc;
  logic [HDR_W-1:0]  hdr_shifted;

  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic              emit;
  status_t           emit_status;
  logic [BYTE_W-1:0] emit_byte;

  lprr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !rsp_valid || !rsp_stall;

  // Dropping the front record; a header that claims more than is stored
  // empties the ring.
  assign span        = SUM_W'(front_hdr) + SUM_W'(HDR_BYTES);
  assign drop_broken = span > SUM_W'(used);
  assign drop_start  = drop_broken ? end_ptr : wrap(SUM_W'(start_ptr) + span);
  assign drop_used   = drop_broken ? '0 : PTR_W'(SUM_W'(used) - span);
  assign end_inc     = wrap(SUM_W'(end_ptr) + SUM_W'(1));

  // Header bytes arrive lowest first and shift in from the top.
  assign hdr_shifted = HDR_W'({mem_rdata, front_hdr} >> 8);

  always_comb begin
    state_next     = state;
    start_next     = start_ptr;
    end_next       = end_ptr;
    used_next      = used;
    left_next      = left;
    push_open_next = push_open;
    front_hdr_next = front_hdr;
    cnt_next       = cnt;
    evicting_next  = evicting;
    cur_len_next   = cur_len;
    cur_room_next  = cur_room;
    hdr_sh_next    = hdr_sh;
    head_take      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = end_ptr;
    mem_wdata      = head.req.payload_byte;
    mem_re         = 1'b0;
    mem_raddr      = wrap(SUM_W'(start_ptr) + SUM_W'(cnt));
    emit           = 1'b0;
    emit_status    = ST_OK;
    emit_byte      = '0;

    case (state)
      S_IDLE: begin
        if (head_valid && out_free) begin
          head_take = 1'b1;
          if (head.req.kind == KIND_PUSH_BYTE) begin
            emit = 1'b1;
            if (!push_open) begin
              emit_status = ST_SEQ_ERR;
            end else begin
              mem_we         = 1'b1;
              end_next       = end_inc;
              used_next      = used + 1'b1;
              left_next      = left - 1'b1;
              push_open_next = (left != LEN_W'(1));
            end
          end else if (push_open) begin
            emit        = 1'b1;
            emit_status = ST_SEQ_ERR;
          end else begin
            case (head.req.kind)
              KIND_PUSH_BEGIN: begin
                if (head.too_long) begin
                  emit        = 1'b1;
                  emit_status = ST_BAD_LEN;
                end else begin
                  cur_len_next  = head.req.record_length;
                  cur_room_next = head_room;
                  state_next    = S_EVICT;
                end
              end
              KIND_POP: begin
                if (used == '0) begin
                  emit        = 1'b1;
                  emit_status = ST_EMPTY;
                end else begin
                  start_next = drop_start;
                  used_next  = drop_used;
                  if (drop_used == '0) begin
                    front_hdr_next = '0;
                    emit           = 1'b1;
                  end else begin
                    evicting_next = 1'b0;
                    cnt_next      = '0;
                    state_next    = S_RD_HDR;
                  end
                end
              end
              KIND_READ: begin
                if (used == '0) begin
                  emit        = 1'b1;
                  emit_status = ST_EMPTY;
                end else if (SUM_W'(head.req.read_index) >= SUM_W'(front_hdr)) begin
                  emit        = 1'b1;
                  emit_status = ST_BAD_INDEX;
                end else begin
                  mem_re     = 1'b1;
                  mem_raddr  = wrap(SUM_W'(start_ptr) + SUM_W'(HDR_BYTES)
                                    + SUM_W'(head.req.read_index));
                  state_next = S_RD_BYTE;
                end
              end
              default: begin
                emit        = 1'b1;
                emit_status = ST_SEQ_ERR;
              end
            endcase
          end
        end
      end

      S_EVICT: begin
        if ((used != '0) && (used > cur_room)) begin
          start_next = drop_start;
          used_next  = drop_used;
          if (drop_used == '0) begin
            front_hdr_next = '0;
          end else begin
            evicting_next = 1'b1;
            cnt_next      = '0;
            state_next    = S_RD_HDR;
          end
        end else begin
          if (used == '0) begin
            front_hdr_next = HDR_W'(cur_len);
          end
          hdr_sh_next = HDR_W'(cur_len);
          cnt_next    = '0;
          state_next  = S_WR_HDR;
        end
      end

      S_RD_HDR: begin
        if (cnt == CNT_W'(HDR_BYTES)) begin
          if (evicting || out_free) begin
            front_hdr_next = hdr_shifted;
            emit           = !evicting;
            state_next     = evicting ? S_EVICT : S_IDLE;
          end
        end else begin
          mem_re = 1'b1;
          if (cnt != '0) begin
            front_hdr_next = hdr_shifted;
          end
          cnt_next = cnt + 1'b1;
        end
      end

      S_WR_HDR: begin
        if ((cnt != CNT_W'(HDR_BYTES - 1)) || out_free) begin
          mem_we      = 1'b1;
          mem_wdata   = hdr_sh[BYTE_W-1:0];
          end_next    = end_inc;
          used_next   = used + 1'b1;
          hdr_sh_next = HDR_W'(hdr_sh >> 8);
          cnt_next    = cnt + 1'b1;
          if (cnt == CNT_W'(HDR_BYTES - 1)) begin
            left_next      = cur_len;
            push_open_next = (cur_len != '0);
            emit           = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end

      S_RD_BYTE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = mem_rdata;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    if (emit) begin
      rsp_next.status       = emit_status;
      rsp_next.read_byte    = emit_byte;
      rsp_next.front_length = LEN_W'(front_hdr_next);
      rsp_next.used_bytes   = USED_W'(used_next);
      rsp_next.is_empty     = (used_next == '0);
      rsp_valid_next        = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start_ptr <= '0;
      end_ptr   <= '0;
      used      <= '0;
      left      <= '0;
      push_open <= 1'b0;
      front_hdr <= '0;
      cnt       <= '0;
      evicting  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      start_ptr <= start_next;
      end_ptr   <= end_next;
      used      <= used_next;
      left      <= left_next;
      push_open <= push_open_next;
      front_hdr <= front_hdr_next;
      cnt       <= cnt_next;
      evicting  <= evicting_next;
      cur_len   <= cur_len_next;
      cur_room  <= cur_room_next;
      hdr_sh    <= hdr_sh_next;
      rsp       <= rsp_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### src/length_prefixed_record_ring.sv
// ----------------------------------------------------------------------------
// length_prefixed_record_ring
// Byte ring of variable-length records with little-endian length headers,
// dropping the oldest records to make room for a new one.
// ----------------------------------------------------------------------------
// Every request item gives exactly one response item. Requests enter a
// two-entry queue, so the request side can keep flowing while a response
// waits, until the queue is full. In the execution unit a payload byte, a
// rejected item and a pop that empties the ring are done in the idle state;
// a read issues its address in the idle state and answers from the
// registered read port of the byte memory. A pop that leaves records behind
// fetches the new front header one byte a cycle. A push begin first evicts
// old records, fetching the new front header after each eviction that
// leaves records behind, then writes its header byte by byte. The byte
// memory needs no clearing pass after reset.
module length_prefixed_record_ring import lprr_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int HDR_BYTES = HDR_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int PTR_W = $clog2(CAPACITY);

  logic             head_valid;
  cmd_t             head;
  logic [PTR_W-1:0] head_room;
  logic             head_take;

  lprr_front #(
    .CAPACITY  (CAPACITY),
    .HDR_BYTES (HDR_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .head_valid (head_valid),
    .head       (head),
    .head_room  (head_room),
    .head_take  (head_take)
  );

  lprr_back #(
    .CAPACITY  (CAPACITY),
    .HDR_BYTES (HDR_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_room  (head_room),
    .head_take  (head_take),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed record ring. A short scripted
// sequence covers the error codes and field extremes. Random record traffic
// follows, with eviction, reads, pops and protocol noise mixed in. Every
// response is compared field by field with a scripted reply or an in-bench model of the ring.
// ----------------------------------------------------------------------------
module tb_top;
  import lprr_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int HDR = HDR_BYTES_DEF;
  localparam longint unsigned HDR_MAX = (64'd1 << (8 * HDR)) - 64'd1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    req_t item;
    logic typed;
    rsp_t want;
  } step_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Model of the ring.
  logic [7:0] ring_mem [CAP];
  int unsigned head_ptr = 0;
  int unsigned tail_ptr = 0;
  int unsigned push_remaining = 0;
  bit push_active = 1'b0;
  bit big_record_done = 1'b0;

  step_row_t script_rows[$];
  rsp_t pending_replies[$];

  int fail_count = 0;
  int items_sent = 0;
  int rsp_taken = 0;
  int taken_noted = 0;
  int hold_left = 0;
  int evicted_records = 0;
  int status_count [5];
  int cycle_count = 0;
  int random_count = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  rsp_t want_now;

  length_prefixed_record_ring dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned ring_fill();
    if (head_ptr <= tail_ptr) return tail_ptr - head_ptr;
    return CAP + tail_ptr - head_ptr;
  endfunction

  function automatic int unsigned front_len();
    int unsigned v;
    v = 0;
    if (ring_fill() == 0) return 0;
    for (int i = 0; i < HDR; i++)
      v |= int'(ring_mem[(head_ptr + i) % CAP]) << (8 * i);
    return v;
  endfunction

  function automatic void drop_front_record();
    int unsigned span;
    span = front_len() + HDR;
    if (span > ring_fill()) head_ptr = tail_ptr;
    else head_ptr = (head_ptr + span) % CAP;
  endfunction

  function automatic void append_byte(logic [7:0] b);
    ring_mem[tail_ptr] = b;
    tail_ptr = (tail_ptr + 1) % CAP;
  endfunction

  // Applies one item to the model and returns the response it must produce.
  function automatic rsp_t ring_reply(req_t r);
    rsp_t o;
    int unsigned need;
    int unsigned fill;
    o = '0;
    o.status = ST_OK;
    if (r.kind == KIND_PUSH_BYTE) begin
      if (!push_active) begin
        o.status = ST_SEQ_ERR;
      end else begin
        append_byte(r.payload_byte);
        push_remaining--;
        if (push_remaining == 0) push_active = 1'b0;
      end
    end else if (push_active) begin
      o.status = ST_SEQ_ERR;
    end else if (r.kind == KIND_PUSH_BEGIN) begin
      need = r.record_length + HDR + 1;
      if (need > CAP || r.record_length > HDR_MAX) begin
        o.status = ST_BAD_LEN;
      end else begin
        while (ring_fill() != 0 && need > CAP - ring_fill()) begin
          drop_front_record();
          evicted_records++;
        end
        for (int i = 0; i < HDR; i++)
          append_byte(8'(r.record_length >> (8 * i)));
        push_remaining = r.record_length;
        push_active = (r.record_length != 0);
      end
    end else if (ring_fill() == 0) begin
      o.status = ST_EMPTY;
    end else if (r.kind == KIND_POP) begin
      drop_front_record();
    end else if (r.read_index >= front_len()) begin
      o.status = ST_BAD_INDEX;
    end else begin
      o.read_byte = ring_mem[(head_ptr + HDR + r.read_index) % CAP];
    end
    fill = ring_fill();
    o.front_length = LEN_W'(front_len());
    o.used_bytes = USED_W'(fill);
    o.is_empty = (fill == 0);
    return o;
  endfunction

  function automatic void add_row(kind_t k, int len, int b, int idx, bit typed,
                                  status_t st = ST_OK, int rb = 0, int fl = 0,
                                  int used = 0, bit emp = 1'b0);
    step_row_t row;
    row.item.kind = k;
    row.item.record_length = LEN_W'(len);
    row.item.payload_byte = BYTE_W'(b);
    row.item.read_index = IDX_W'(idx);
    row.typed = typed;
    row.want.status = st;
    row.want.read_byte = BYTE_W'(rb);
    row.want.front_length = LEN_W'(fl);
    row.want.used_bytes = USED_W'(used);
    row.want.is_empty = emp;
    script_rows.push_back(row);
  endfunction

  function automatic logic [LEN_W-1:0] pick_record_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return LEN_W'($urandom_range(0, 4));
    if (r < 70) return LEN_W'($urandom_range(5, 30));
    if (r < 88) return LEN_W'($urandom_range(31, 120));
    if (r < 97) return LEN_W'($urandom_range(121, 400));
    return LEN_W'($urandom_range(401, CAP - HDR - 1));
  endfunction

  // Mostly well-formed records with random content; the rest is noise.
  // The first record of the random part has the largest length that fits.
  function automatic req_t next_random_item();
    req_t it;
    int unsigned pick;
    int unsigned flen;
    it = req_t'({$urandom(), $urandom()});
    pick = $urandom_range(0, 99);
    flen = front_len();
    if (push_active) begin
      if (pick < 94) it.kind = KIND_PUSH_BYTE;
      else if (pick < 96) it.kind = KIND_PUSH_BEGIN;
      else if (pick < 98) it.kind = KIND_POP;
      else it.kind = KIND_READ;
    end else if (!big_record_done || pick < 50) begin
      it.kind = KIND_PUSH_BEGIN;
      it.record_length = big_record_done ? pick_record_length() : LEN_W'(CAP - HDR - 1);
      big_record_done = 1'b1;
    end else if (pick < 55) begin
      it.kind = KIND_PUSH_BEGIN;
      it.record_length = LEN_W'($urandom_range(CAP - HDR, 65535));
    end else if (pick < 68) begin
      it.kind = KIND_POP;
    end else if (pick < 92) begin
      it.kind = KIND_READ;
      if (flen != 0 && $urandom_range(0, 4) != 0)
        it.read_index = IDX_W'($urandom_range(0, flen - 1));
    end else begin
      it.kind = KIND_PUSH_BYTE;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input req_t item, input bit typed, input rsp_t typed_reply);
    int gap;
    rsp_t reply;
    if (items_sent % 90 == 0) sender_calm = ($urandom_range(0, 2) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    reply = ring_reply(item);
    status_count[int'(reply.status)]++;
    pending_replies.push_back(typed ? typed_reply : reply);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with none outstanding", rsp_taken));
      end else begin
        want_now = pending_replies.pop_front();
        if (rsp.status !== want_now.status)
          report_mismatch($sformatf("response %0d status got %0d want %0d",
                                    rsp_taken, rsp.status, want_now.status));
        if (rsp.read_byte !== want_now.read_byte)
          report_mismatch($sformatf("response %0d read_byte got %0h want %0h",
                                    rsp_taken, rsp.read_byte, want_now.read_byte));
        if (rsp.front_length !== want_now.front_length)
          report_mismatch($sformatf("response %0d front_length got %0d want %0d",
                                    rsp_taken, rsp.front_length, want_now.front_length));
        if (rsp.used_bytes !== want_now.used_bytes)
          report_mismatch($sformatf("response %0d used_bytes got %0d want %0d",
                                    rsp_taken, rsp.used_bytes, want_now.used_bytes));
        if (rsp.is_empty !== want_now.is_empty)
          report_mismatch($sformatf("response %0d is_empty got %0b want %0b",
                                    rsp_taken, rsp.is_empty, want_now.is_empty));
      end
      rsp_taken++;
    end
  end

  // The receiver holds off a random number of cycles after each response.
  always @(negedge clk) begin
    if (rsp_taken != taken_noted) begin
      taken_noted = rsp_taken;
      if (rsp_taken % 80 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
      hold_left = receiver_calm ? 0 : $urandom_range(0, 6);
    end
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    foreach (status_count[i]) status_count[i] = 0;

    // Rows with a typed reply can be read straight off the ring's behavior.
    add_row(KIND_POP,        16'hFFFF, 8'hFF, 10'h3FF, 1, ST_EMPTY, 0, 0, 0, 1);
    add_row(KIND_READ,       0,        0,     0,       1, ST_EMPTY, 0, 0, 0, 1);
    add_row(KIND_PUSH_BYTE,  0,        8'hFF, 0,       1, ST_SEQ_ERR, 0, 0, 0, 1);
    add_row(KIND_PUSH_BEGIN, CAP - HDR, 0,    0,       1, ST_BAD_LEN, 0, 0, 0, 1);
    add_row(KIND_PUSH_BEGIN, 16'hFFFF, 8'hFF, 10'h3FF, 1, ST_BAD_LEN, 0, 0, 0, 1);
    add_row(KIND_PUSH_BEGIN, 0,        0,     0,       1, ST_OK, 0, 0, 2, 0);
    add_row(KIND_POP,        0,        0,     0,       1, ST_OK, 0, 0, 0, 1);
    add_row(KIND_PUSH_BEGIN, 3,        0,     0,       1, ST_OK, 0, 3, 2, 0);
    add_row(KIND_PUSH_BEGIN, 5,        0,     0,       1, ST_SEQ_ERR, 0, 3, 2, 0);
    add_row(KIND_POP,        0,        0,     0,       1, ST_SEQ_ERR, 0, 3, 2, 0);
    add_row(KIND_READ,       0,        0,     0,       1, ST_SEQ_ERR, 0, 3, 2, 0);
    add_row(KIND_PUSH_BYTE,  16'hFFFF, 8'h00, 10'h3FF, 1, ST_OK, 0, 3, 3, 0);
    add_row(KIND_PUSH_BYTE,  0,        8'hFF, 0,       1, ST_OK, 0, 3, 4, 0);
    add_row(KIND_PUSH_BYTE,  0,        8'hA5, 0,       1, ST_OK, 0, 3, 5, 0);
    add_row(KIND_PUSH_BYTE,  0,        8'h3C, 0,       1, ST_SEQ_ERR, 0, 3, 5, 0);
    add_row(KIND_READ,       0,        0,     1,       1, ST_OK, 8'hFF, 3, 5, 0);
    add_row(KIND_READ,       0,        0,     3,       1, ST_BAD_INDEX, 0, 3, 5, 0);
    add_row(KIND_READ,       16'hFFFF, 8'hFF, 10'h3FF, 1, ST_BAD_INDEX, 0, 3, 5, 0);
    add_row(KIND_PUSH_BEGIN, 1,        0,     0,       0);
    add_row(KIND_PUSH_BYTE,  0,        8'h5A, 0,       0);
    add_row(KIND_READ,       0,        0,     2,       0);
    add_row(KIND_POP,        0,        0,     0,       0);
    add_row(KIND_READ,       0,        0,     0,       0);
    add_row(KIND_POP,        0,        0,     0,       0);
    add_row(KIND_POP,        0,        0,     0,       0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (script_rows[i])
      send_item(script_rows[i].item, script_rows[i].typed, script_rows[i].want);
    hold_until_drained();

    while (random_count < RANDOM_ITEMS) begin
      send_item(next_random_item(), 1'b0, '0);
      random_count++;
      if (random_count == RANDOM_ITEMS / 2) hold_until_drained();
    end

    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d responses, %0d records evicted for room.",
             items_sent, rsp_taken, evicted_records);
    $display("Status mix ok/bad_len/empty/bad_index/seq_err: %0d/%0d/%0d/%0d/%0d.",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4]);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
